// ===== src/jfhl_pkg.sv =====
`default_nettype none
package jfhl_pkg;

  typedef enum logic [3:0] {
    PH_SIG0 = 4'd0,
    PH_SIG1 = 4'd1,
    PH_MARK = 4'd2,
    PH_LENH = 4'd3,
    PH_LENL = 4'd4,
    PH_SKIP = 4'd5,
    PH_SOF  = 4'd6,
    PH_DONE = 4'd7,
    PH_FAIL = 4'd8
  } phase_t;

  localparam logic [7:0] MARK_FILL = 8'hff;
  localparam logic [7:0] MARK_SOI  = 8'hd8;
  localparam logic [7:0] MARK_EOI  = 8'hd9;
  localparam logic [7:0] MARK_SOS  = 8'hda;
  localparam logic [7:0] MARK_TEM  = 8'h01;
  localparam logic [7:0] MARK_RST0 = 8'hd0;
  localparam logic [7:0] MARK_RST7 = 8'hd7;
  localparam logic [7:0] SOF_FIRST = 8'hc0;
  localparam logic [7:0] SOF_LAST  = 8'hcf;
  localparam logic [7:0] MARK_DHT  = 8'hc4;
  localparam logic [7:0] MARK_JPG  = 8'hc8;
  localparam logic [7:0] MARK_DAC  = 8'hcc;

  localparam logic [15:0] MIN_SEG_LEN = 16'd2;
  localparam logic [15:0] MIN_SOF_LEN = 16'd7;
  localparam logic [2:0]  MIN_FILE_BYTES = 3'd4;
  localparam logic [7:0]  SOF_POS_SAT = 8'd5;

  typedef struct packed {
    logic        found;
    logic [15:0] width;
    logic [15:0] height;
  } frame_info_t;

  function automatic logic is_sof(input logic [7:0] m);
    is_sof = (m >= SOF_FIRST) && (m <= SOF_LAST) &&
             (m != MARK_DHT) && (m != MARK_JPG) && (m != MARK_DAC);
  endfunction

endpackage
`default_nettype wire

// ===== src/jfhl_parser.sv =====
`default_nettype none
module jfhl_parser (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                take,
  input  wire logic [7:0]          data_byte,
  input  wire logic                first_of_file,
  input  wire logic                last_of_file,
  output jfhl_pkg::frame_info_t    info
);
  import jfhl_pkg::*;

  phase_t      parse_phase, parse_phase_next;
  logic [2:0]  bytes_seen, bytes_seen_next;
  logic [15:0] segment_left, segment_left_next;
  logic [7:0]  length_high, length_high_next;
  logic        in_frame_segment, in_frame_segment_next;
  logic [15:0] frame_height, frame_height_next;
  logic [15:0] frame_width, frame_width_next;

  phase_t      ph;
  logic [2:0]  bs;
  logic [15:0] sl;
  logic [7:0]  lh;
  logic        ifs;
  logic [15:0] seg_len;
  logic [15:0] sl_dec;

  always_comb begin
    // a new file starts from the cleared state
    ph  = first_of_file ? PH_SIG0 : parse_phase;
    bs  = first_of_file ? 3'd0 : bytes_seen;
    sl  = first_of_file ? 16'd0 : segment_left;
    lh  = first_of_file ? 8'd0 : length_high;
    ifs = first_of_file ? 1'b0 : in_frame_segment;
    frame_height_next = first_of_file ? 16'd0 : frame_height;
    frame_width_next  = first_of_file ? 16'd0 : frame_width;

    parse_phase_next      = ph;
    bytes_seen_next       = (bs < MIN_FILE_BYTES) ? bs + 3'd1 : bs;
    segment_left_next     = sl;
    length_high_next      = lh;
    in_frame_segment_next = ifs;
    seg_len = {lh, data_byte};
    sl_dec  = (sl != 16'd0) ? sl - 16'd1 : sl;

    case (ph)
      PH_SIG0: parse_phase_next = (data_byte == MARK_FILL) ? PH_SIG1 : PH_FAIL;
      PH_SIG1: parse_phase_next = (data_byte == MARK_SOI) ? PH_MARK : PH_FAIL;
      PH_MARK: begin
        if (data_byte == MARK_FILL) begin
          parse_phase_next = PH_MARK;
        end else if (data_byte == MARK_EOI || data_byte == MARK_SOS) begin
          parse_phase_next = PH_FAIL;
        end else if (data_byte == MARK_TEM ||
                     (data_byte >= MARK_RST0 && data_byte <= MARK_RST7)) begin
          parse_phase_next = PH_MARK;
        end else begin
          in_frame_segment_next = is_sof(data_byte);
          parse_phase_next = PH_LENH;
        end
      end
      PH_LENH: begin
        length_high_next = data_byte;
        parse_phase_next = PH_LENL;
      end
      PH_LENL: begin
        if (seg_len < MIN_SEG_LEN || (ifs && seg_len < MIN_SOF_LEN)) begin
          parse_phase_next = PH_FAIL;
        end else begin
          segment_left_next = seg_len - MIN_SEG_LEN;
          if (ifs) begin
            length_high_next = 8'd0;
            parse_phase_next = PH_SOF;
          end else begin
            parse_phase_next = (seg_len == MIN_SEG_LEN) ? PH_MARK : PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        segment_left_next = sl_dec;
        if (sl_dec == 16'd0) parse_phase_next = PH_MARK;
      end
      PH_SOF: begin
        // body position: precision, height hi/lo, width hi/lo
        case (lh)
          8'd1: frame_height_next[15:8] = data_byte;
          8'd2: frame_height_next[7:0]  = data_byte;
          8'd3: frame_width_next[15:8]  = data_byte;
          8'd4: frame_width_next[7:0]   = data_byte;
          default: ;
        endcase
        if (lh < SOF_POS_SAT) length_high_next = lh + 8'd1;
        segment_left_next = sl_dec;
        if (sl_dec == 16'd0) parse_phase_next = PH_DONE;
      end
      default: ;
    endcase

    info.found  = (parse_phase_next == PH_DONE) && (bytes_seen_next >= MIN_FILE_BYTES) &&
                  (frame_width_next != 16'd0) && (frame_height_next != 16'd0);
    info.width  = info.found ? frame_width_next : 16'd0;
    info.height = info.found ? frame_height_next : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (take && last_of_file)) begin
      parse_phase      <= PH_SIG0;
      bytes_seen       <= 3'd0;
      segment_left     <= 16'd0;
      length_high      <= 8'd0;
      in_frame_segment <= 1'b0;
      frame_height     <= 16'd0;
      frame_width      <= 16'd0;
    end else if (take) begin
      parse_phase      <= parse_phase_next;
      bytes_seen       <= bytes_seen_next;
      segment_left     <= segment_left_next;
      length_high      <= length_high_next;
      in_frame_segment <= in_frame_segment_next;
      frame_height     <= frame_height_next;
      frame_width      <= frame_width_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/jpeg_frame_header_locator.sv =====
`default_nettype none
// Scans a JPEG file presented one byte per transaction and reports the size
// of the first complete start-of-frame segment. One byte is accepted every
// cycle while in_ready is high; the per-byte work is a marker/length phase
// update in the parser. The byte flagged last_of_file produces one result,
// which is registered in a result stage and then in the output register,
// where the 16x16 width*height multiply is done. The two registers let two
// results queue, so input stalls only when both hold one and out_ready is low.
module jpeg_frame_header_locator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        first_of_file,
  input  wire logic        last_of_file,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             frame_found,
  output logic [15:0]      image_width,
  output logic [15:0]      image_height,
  output logic [35:0]      decoded_size
);
  import jfhl_pkg::*;

  logic        take;
  logic        out_load;
  frame_info_t info;
  frame_info_t info_a;
  logic        a_valid;

  assign out_load = !out_valid || out_ready;
  assign in_ready = !a_valid || out_load;
  assign take     = in_valid && in_ready;

  jfhl_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .data_byte     (data_byte),
    .first_of_file (first_of_file),
    .last_of_file  (last_of_file),
    .info          (info)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (take && last_of_file) begin
      a_valid <= 1'b1;
    end else if (out_load) begin
      a_valid <= 1'b0;
    end
    if (take && last_of_file) info_a <= info;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= a_valid;
    end
    if (out_load && a_valid) begin
      frame_found  <= info_a.found;
      image_width  <= info_a.width;
      image_height <= info_a.height;
      // full 32-bit product before the x16 shift
      decoded_size <= {{16'd0, info_a.width} * {16'd0, info_a.height}, 4'b0000};
    end
  end

  a_no_frame_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_found |->
      image_width == 16'd0 && image_height == 16'd0 && decoded_size == 36'd0)
    else $error("not-found result carries nonzero size");

  a_found_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_found |-> image_width != 16'd0 && image_height != 16'd0)
    else $error("found result with zero dimension");

  a_last_queues: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_of_file |=> a_valid)
    else $error("last byte did not queue a result");

endmodule
`default_nettype wire
